// ----- hw/rtl/kgam_pkg.sv -----
// Package: shared constants, key mapping tables and controller/datapath structs.
`default_nettype none
package kgam_pkg;

  localparam int AXIS_KEYS   = 6;
  localparam int BUTTON_KEYS = 14;
  localparam int IDX_W       = (AXIS_KEYS > 1) ? $clog2(AXIS_KEYS) : 1;
  localparam int CODE_W      = 10;
  localparam int VAL_W       = 8;
  localparam int KVAL_W      = 2;
  localparam int CFG_IDX_W   = 2;

  localparam logic [CFG_IDX_W-1:0] REG_MID  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_STEP = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MAX  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MIN  = 2'd3;

  localparam logic [VAL_W-1:0] ABS_MID_RST    = 8'd127;
  localparam logic [VAL_W-1:0] ABS_OFFSET_RST = 8'd20;
  localparam logic [VAL_W-1:0] ABS_MAX_RST    = 8'd255;
  localparam logic [VAL_W-1:0] ABS_MIN_RST    = 8'd0;

  localparam logic EVT_BUTTON = 1'b0;
  localparam logic EVT_AXIS   = 1'b1;
  localparam logic KIND_KEY   = 1'b0;
  localparam logic KIND_TICK  = 1'b1;

  localparam logic [CODE_W-1:0] BTN_KEY [BUTTON_KEYS] = '{
    10'd38, 10'd39, 10'd37, 10'd24, 10'd16, 10'd18, 10'd23,
    10'd25, 10'd14, 10'd28, 10'd3,  10'd4,  10'd11, 10'd12
  };
  localparam logic [CODE_W-1:0] BTN_CODE [BUTTON_KEYS] = '{
    10'd304, 10'd305, 10'd307, 10'd308, 10'd312, 10'd310, 10'd311,
    10'd313, 10'd314, 10'd315, 10'd546, 10'd547, 10'd544, 10'd545
  };

  // ascending key code order
  localparam logic [CODE_W-1:0] AX_KEY [AXIS_KEYS] = '{
    10'd17, 10'd30, 10'd31, 10'd32, 10'd33, 10'd36
  };
  localparam logic [CODE_W-1:0] AX_CODE [AXIS_KEYS] = '{
    10'd1, 10'd0, 10'd1, 10'd0, 10'd3, 10'd3
  };
  localparam logic AX_INC [AXIS_KEYS] = '{
    1'b0, 1'b0, 1'b1, 1'b1, 1'b0, 1'b1
  };

  typedef struct packed {
    logic latch;
    logic key_exec;
    logic idx_clr;
    logic idx_inc;
    logic tick_exec;
  } cmd_t;

  typedef struct packed {
    logic is_tick;
    logic key_hit;
    logic out_free;
    logic any_ahead;
    logic cur_pressed;
    logic last_here;
  } sts_t;

endpackage
`default_nettype wire

// ----- hw/rtl/kgam_if.sv -----
// Interfaces: key event input channel and gamepad event result channel.
`default_nettype none
interface kgam_key_if;
  logic                          valid;
  logic                          ready;
  logic                          kind;
  logic [kgam_pkg::CODE_W-1:0]   key_code;
  logic [kgam_pkg::KVAL_W-1:0]   key_value;
  modport source (output valid, kind, key_code, key_value, input ready);
  modport sink   (input valid, kind, key_code, key_value, output ready);
endinterface

interface kgam_pad_if;
  logic                          valid;
  logic                          ready;
  logic                          event_kind;
  logic [kgam_pkg::CODE_W-1:0]   event_code;
  logic [kgam_pkg::VAL_W-1:0]    event_value;
  logic                          last;
  modport source (output valid, event_kind, event_code, event_value, last, input ready);
  modport sink   (input valid, event_kind, event_code, event_value, last, output ready);
endinterface
`default_nettype wire

// ----- hw/rtl/kgam_ctrl.sv -----
// Controller: sequences input capture, key handling and the tick scan.
`default_nettype none
module kgam_ctrl (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           in_fire,
  input  wire kgam_pkg::sts_t sts,
  output logic                in_ready,
  output kgam_pkg::cmd_t      cmd
);

  typedef enum logic [1:0] {ST_IDLE, ST_DECODE, ST_SCAN} state_t;

  state_t state_r, state_nxt;

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    in_ready  = (state_r == ST_IDLE);
    unique case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          cmd.latch = 1'b1;
          state_nxt = ST_DECODE;
        end
      end
      ST_DECODE: begin
        if (sts.is_tick) begin
          cmd.idx_clr = 1'b1;
          state_nxt   = ST_SCAN;
        end else if (!sts.key_hit) begin
          state_nxt = ST_IDLE;
        end else if (sts.out_free) begin
          cmd.key_exec = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      ST_SCAN: begin
        if (!sts.any_ahead) begin
          state_nxt = ST_IDLE;
        end else if (!sts.cur_pressed) begin
          cmd.idx_inc = 1'b1;
        end else if (sts.out_free) begin
          cmd.tick_exec = 1'b1;
          if (sts.last_here) state_nxt = ST_IDLE;
          else cmd.idx_inc = 1'b1;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= ST_IDLE;
    else        state_r <= state_nxt;
  end

endmodule
`default_nettype wire

// ----- hw/rtl/kgam_dp.sv -----
// Datapath: config registers, axis state, table lookup and result register.
`default_nettype none
module kgam_dp (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              cfg_we,
  input  wire logic [kgam_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [kgam_pkg::VAL_W-1:0]        cfg_value,
  input  wire logic                              in_kind,
  input  wire logic [kgam_pkg::CODE_W-1:0]       in_key_code,
  input  wire logic [kgam_pkg::KVAL_W-1:0]       in_key_value,
  input  wire kgam_pkg::cmd_t                    cmd,
  output kgam_pkg::sts_t                         sts,
  input  wire logic                              out_ready,
  output logic                                   out_valid,
  output logic                                   out_event_kind,
  output logic [kgam_pkg::CODE_W-1:0]            out_event_code,
  output logic [kgam_pkg::VAL_W-1:0]             out_event_value,
  output logic                                   out_last
);

  localparam int AK = kgam_pkg::AXIS_KEYS;
  localparam int IW = kgam_pkg::IDX_W;
  localparam int VW = kgam_pkg::VAL_W;
  localparam int CW = kgam_pkg::CODE_W;

  logic [VW-1:0] mid_r, step_r, max_r, min_r;
  logic [VW-1:0] pos_r [AK];
  logic [AK-1:0] pressed_r;
  logic          kind_r;
  logic [CW-1:0] key_r;
  logic [kgam_pkg::KVAL_W-1:0] val_r;
  logic [IW-1:0] idx_r;

  logic          out_valid_r, out_kind_r, out_last_r;
  logic [CW-1:0] out_code_r;
  logic [VW-1:0] out_value_r;

  logic          btn_hit, ax_hit;
  logic [CW-1:0] btn_code;
  logic [IW-1:0] ax_idx;
  logic [VW-1:0] press_pos, tick_pos;
  logic [AK-1:0] ahead_mask, later_mask;

  function automatic logic [VW-1:0] move_axis(input logic [VW-1:0] base, input logic inc,
                                               input logic [VW-1:0] stp,
                                               input logic [VW-1:0] mx,
                                               input logic [VW-1:0] mn);
    logic [VW:0] sum;
    logic [VW:0] floor_v;
    sum     = {1'b0, base} + {1'b0, stp};
    floor_v = {1'b0, stp} + {1'b0, mn};
    if (inc) return (sum > {1'b0, mx}) ? mx : sum[VW-1:0];
    return ({1'b0, base} < floor_v) ? mn : base - stp;
  endfunction

  always_comb begin
    btn_hit  = 1'b0;
    btn_code = '0;
    for (int i = 0; i < kgam_pkg::BUTTON_KEYS; i++) begin
      if (kgam_pkg::BTN_KEY[i] == key_r) begin
        btn_hit  = 1'b1;
        btn_code = kgam_pkg::BTN_CODE[i];
      end
    end
    ax_hit = 1'b0;
    ax_idx = '0;
    for (int i = 0; i < AK; i++) begin
      if (kgam_pkg::AX_KEY[i] == key_r) begin
        ax_hit = 1'b1;
        ax_idx = IW'(i);
      end
    end
    for (int i = 0; i < AK; i++) begin
      ahead_mask[i] = (IW'(i) >= idx_r);
      later_mask[i] = (IW'(i) > idx_r);
    end
  end

  assign press_pos = (val_r != '0) ?
                     move_axis(mid_r, kgam_pkg::AX_INC[ax_idx], step_r, max_r, min_r) : mid_r;
  assign tick_pos  = move_axis(pos_r[idx_r], kgam_pkg::AX_INC[idx_r], step_r, max_r, min_r);

  always_comb begin
    sts.is_tick     = (kind_r == kgam_pkg::KIND_TICK);
    sts.key_hit     = btn_hit | ax_hit;
    sts.out_free    = !out_valid_r || out_ready;
    sts.any_ahead   = |(pressed_r & ahead_mask);
    sts.cur_pressed = pressed_r[idx_r];
    sts.last_here   = !(|(pressed_r & later_mask));
  end

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      kind_r <= in_kind;
      key_r  <= in_key_code;
      val_r  <= in_key_value;
    end
    if (cmd.idx_clr)      idx_r <= '0;
    else if (cmd.idx_inc) idx_r <= idx_r + 1'b1;
    if (cmd.key_exec) begin
      out_last_r <= 1'b1;
      if (btn_hit) begin
        out_kind_r  <= kgam_pkg::EVT_BUTTON;
        out_code_r  <= btn_code;
        out_value_r <= VW'(val_r);
      end else begin
        out_kind_r  <= kgam_pkg::EVT_AXIS;
        out_code_r  <= kgam_pkg::AX_CODE[ax_idx];
        out_value_r <= press_pos;
      end
    end else if (cmd.tick_exec) begin
      out_kind_r  <= kgam_pkg::EVT_AXIS;
      out_code_r  <= kgam_pkg::AX_CODE[idx_r];
      out_value_r <= tick_pos;
      out_last_r  <= sts.last_here;
    end
    if (!rst_n) begin
      mid_r       <= kgam_pkg::ABS_MID_RST;
      step_r      <= kgam_pkg::ABS_OFFSET_RST;
      max_r       <= kgam_pkg::ABS_MAX_RST;
      min_r       <= kgam_pkg::ABS_MIN_RST;
      pressed_r   <= '0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < AK; i++) pos_r[i] <= kgam_pkg::ABS_MID_RST;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          kgam_pkg::REG_MID:  mid_r  <= cfg_value;
          kgam_pkg::REG_STEP: step_r <= cfg_value;
          kgam_pkg::REG_MAX:  max_r  <= cfg_value;
          kgam_pkg::REG_MIN:  min_r  <= cfg_value;
          default: ;
        endcase
      end
      if (cmd.key_exec && !btn_hit) begin
        pos_r[ax_idx]     <= press_pos;
        pressed_r[ax_idx] <= (val_r != '0);
      end else if (cmd.tick_exec) begin
        pos_r[idx_r] <= tick_pos;
      end
      if (cmd.key_exec || cmd.tick_exec) out_valid_r <= 1'b1;
      else if (out_ready)                out_valid_r <= 1'b0;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_event_kind  = out_kind_r;
  assign out_event_code  = out_code_r;
  assign out_event_value = out_value_r;
  assign out_last        = out_last_r;

endmodule
`default_nettype wire

// ----- hw/rtl/key_to_gamepad_axis_mapper.sv -----
// Top level: keyboard events to gamepad button and axis events.
// Key event: decode, then result register; a new event is taken only once the result is registered.
// Tick: decode, then a scan over the axis slots up to the last pressed key (the scan ends at
//   once if none is pressed); each pressed slot gives a result, registered from its scan step.
// A result waiting on out ready holds decode or scan until the output register frees.
// Reset (synchronous, rst_n low): registers to defaults, positions to 127, none pressed.
`default_nettype none
module key_to_gamepad_axis_mapper (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           cfg_we,
  input  wire logic [kgam_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [kgam_pkg::VAL_W-1:0]     cfg_value,
  kgam_key_if.sink                            in_evt,
  kgam_pad_if.source                          out_evt
);

  kgam_pkg::cmd_t cmd;
  kgam_pkg::sts_t sts;
  logic           in_fire;

  assign in_fire = in_evt.valid && in_evt.ready;

  kgam_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_fire  (in_fire),
    .sts      (sts),
    .in_ready (in_evt.ready),
    .cmd      (cmd)
  );

  kgam_dp u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_value       (cfg_value),
    .in_kind         (in_evt.kind),
    .in_key_code     (in_evt.key_code),
    .in_key_value    (in_evt.key_value),
    .cmd             (cmd),
    .sts             (sts),
    .out_ready       (out_evt.ready),
    .out_valid       (out_evt.valid),
    .out_event_kind  (out_evt.event_kind),
    .out_event_code  (out_evt.event_code),
    .out_event_value (out_evt.event_value),
    .out_last        (out_evt.last)
  );

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> !in_evt.ready)
    else $error("input taken while a transaction is in progress");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.key_exec || cmd.tick_exec) |-> (!out_evt.valid || out_evt.ready))
    else $error("pending result overwritten");

  a_one_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.latch, cmd.key_exec, cmd.tick_exec}))
    else $error("conflicting datapath commands");

endmodule
`default_nettype wire
